FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// depends on nothing; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

FILE: rtl/iss_pkg.sv
// shared types, codes and the microcode rom of the indexed sequential search unit
// depends on nothing
`timescale 1ns / 1ps

package iss_pkg;

  // default sizes
  localparam int unsigned ArrayDepthDef = 256;
  localparam int unsigned IndexDepthDef = 64;
  localparam int unsigned BlockSizeDef  = 4;

  // field widths fixed by the interface
  localparam int unsigned KeyW   = 32;
  localparam int unsigned PosW   = 8;
  localparam int unsigned OpW    = 2;
  localparam int unsigned CompW  = 3;
  localparam int unsigned AlenW  = 9;
  localparam int unsigned IlenW  = 7;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 9;

  // operation codes
  localparam logic [OpW-1:0] OP_WRITE_KEY   = 2'd0;
  localparam logic [OpW-1:0] OP_WRITE_INDEX = 2'd1;
  localparam logic [OpW-1:0] OP_SEARCH      = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ARRAY_LENGTH = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_INDEX_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    ST_FOUND        = 2'd0,
    ST_NO_BLOCK     = 2'd1,
    ST_NOT_IN_BLOCK = 2'd2
  } status_e;

  // microprogram steps
  localparam int unsigned StepW = 4;
  typedef enum logic [StepW-1:0] {
    S_WAIT       = 4'd0,
    S_SETUP      = 4'd1,
    S_LO         = 4'd2,
    S_PAIR       = 4'd3,
    S_EMIT_NOBLK = 4'd4,
    S_BINIT      = 4'd5,
    S_BCHK       = 4'd6,
    S_BCMP       = 4'd7,
    S_EMIT_NOTIN = 4'd8,
    S_EMIT_FOUND = 4'd9
  } step_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_SEARCH,
    C_SHORT,
    C_MATCH,
    C_MORE,
    C_BEND,
    C_HIT,
    C_BUSY
  } cond_e;

  // datapath controls of one microword
  typedef struct packed {
    logic    in_rdy;
    logic    idx_rd;
    logic    lo_ld;
    logic    pair_step;
    logic    blk_init;
    logic    key_cmp;
    logic    emit;
    status_e status;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic search_acc;
    logic short_idx;
    logic pair_match;
    logic pair_more;
    logic blk_end;
    logic key_hit;
    logic out_busy;
  } flags_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_e cond_a;
    step_e tgt_a;
    cond_e cond_b;
    step_e tgt_b;
  } uword_t;

  // control store; a step without a taken jump falls through to the next
  function automatic uword_t ucode(step_e s);
    uword_t w;
    w = '0;
    w.cond_a = C_NONE;
    w.tgt_a  = S_WAIT;
    w.cond_b = C_NONE;
    w.tgt_b  = S_WAIT;
    w.ctrl.status = ST_FOUND;
    unique case (s)
      S_WAIT: begin
        w.ctrl.in_rdy = 1'b1;
        w.cond_a = C_SEARCH;
        w.tgt_a  = S_SETUP;
        w.cond_b = C_ALWAYS;
        w.tgt_b  = S_WAIT;
      end
      S_SETUP: begin
        w.ctrl.idx_rd = 1'b1;
        w.cond_a = C_SHORT;
        w.tgt_a  = S_EMIT_NOBLK;
      end
      S_LO: begin
        w.ctrl.idx_rd = 1'b1;
        w.ctrl.lo_ld  = 1'b1;
      end
      S_PAIR: begin
        w.ctrl.idx_rd    = 1'b1;
        w.ctrl.pair_step = 1'b1;
        w.cond_a = C_MATCH;
        w.tgt_a  = S_BINIT;
        w.cond_b = C_MORE;
        w.tgt_b  = S_PAIR;
      end
      S_EMIT_NOBLK: begin
        w.ctrl.emit   = 1'b1;
        w.ctrl.status = ST_NO_BLOCK;
        w.cond_a = C_BUSY;
        w.tgt_a  = S_EMIT_NOBLK;
        w.cond_b = C_ALWAYS;
        w.tgt_b  = S_WAIT;
      end
      S_BINIT: begin
        w.ctrl.blk_init = 1'b1;
      end
      S_BCHK: begin
        w.cond_a = C_BEND;
        w.tgt_a  = S_EMIT_NOTIN;
      end
      S_BCMP: begin
        w.ctrl.key_cmp = 1'b1;
        w.cond_a = C_HIT;
        w.tgt_a  = S_EMIT_FOUND;
        w.cond_b = C_ALWAYS;
        w.tgt_b  = S_BCHK;
      end
      S_EMIT_NOTIN: begin
        w.ctrl.emit   = 1'b1;
        w.ctrl.status = ST_NOT_IN_BLOCK;
        w.cond_a = C_BUSY;
        w.tgt_a  = S_EMIT_NOTIN;
        w.cond_b = C_ALWAYS;
        w.tgt_b  = S_WAIT;
      end
      S_EMIT_FOUND: begin
        w.ctrl.emit   = 1'b1;
        w.ctrl.status = ST_FOUND;
        w.cond_a = C_BUSY;
        w.tgt_a  = S_EMIT_FOUND;
        w.cond_b = C_ALWAYS;
        w.tgt_b  = S_WAIT;
      end
      default: begin
        w.cond_a = C_ALWAYS;
        w.tgt_a  = S_WAIT;
      end
    endcase
    return w;
  endfunction

  function automatic logic cond_true(cond_e c, flags_t f);
    logic r;
    r = 1'b0;
    unique case (c)
      C_NONE:   r = 1'b0;
      C_ALWAYS: r = 1'b1;
      C_SEARCH: r = f.search_acc;
      C_SHORT:  r = f.short_idx;
      C_MATCH:  r = f.pair_match;
      C_MORE:   r = f.pair_more;
      C_BEND:   r = f.blk_end;
      C_HIT:    r = f.key_hit;
      C_BUSY:   r = f.out_busy;
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/iss_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module iss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/iss_seq.sv
// microcode sequencer: step register, control rom lookup and two-way jumps
// depends on iss_pkg
`timescale 1ns / 1ps

module iss_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  iss_pkg::flags_t flags_i,
  output iss_pkg::ctrl_t  ctrl_o
);

  iss_pkg::step_e  step_q, step_d;
  iss_pkg::uword_t uword;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= iss_pkg::S_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    uword = iss_pkg::ucode(step_q);
    if (iss_pkg::cond_true(uword.cond_a, flags_i)) begin
      step_d = uword.tgt_a;
    end else if (iss_pkg::cond_true(uword.cond_b, flags_i)) begin
      step_d = uword.tgt_b;
    end else begin
      step_d = iss_pkg::step_e'(step_q + iss_pkg::StepW'(1));
    end
  end

  assign ctrl_o = uword.ctrl;

endmodule

FILE: rtl/indexed_sequential_search_unit.sv
// top level of the indexed sequential search unit: key and index rams, search datapath
// depends on iss_pkg, iss_ram, iss_seq and assert_macros.svh
//
//   channel   direction  handshake                 payload
//   cfg       in         cfg_we_i                  cfg_index_i, cfg_data_i
//   in        in         in_valid_i / in_ready_o   operation_i, position_i, value_i
//   out       out        out_valid_o / out_ready_i status_o, found_position_o, comparisons_o
//
// a load gives no result; a search closes the input until its result is loaded. a short
// index gives no-block without a pair test; else index pairs are tested (one index ram
// read per cycle) and, on a match, the keys of its clipped block are compared (read then
// compare on the key ram); no matching pair gives no-block, a key miss not-in-block.
// reset clears control and lengths only; ram contents stay undefined, no clearing pass.
// a finished result waits in the output register while the next request is taken;
// a new result stalls the sequencer until that register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module indexed_sequential_search_unit #(
  parameter int unsigned ARRAY_DEPTH = iss_pkg::ArrayDepthDef,
  parameter int unsigned INDEX_DEPTH = iss_pkg::IndexDepthDef,
  parameter int unsigned BLOCK_SIZE  = iss_pkg::BlockSizeDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [iss_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [iss_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [iss_pkg::OpW-1:0]      operation_i,
  input  logic [iss_pkg::PosW-1:0]     position_i,
  input  logic signed [iss_pkg::KeyW-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [iss_pkg::PosW-1:0]     found_position_o,
  output logic [iss_pkg::CompW-1:0]    comparisons_o
);

  localparam int unsigned KW   = iss_pkg::KeyW;
  localparam int unsigned AAW  = $clog2(ARRAY_DEPTH);
  localparam int unsigned IAW  = $clog2(INDEX_DEPTH);
  localparam int unsigned PW   = iss_pkg::IlenW;
  localparam int unsigned BSW  = $clog2(BLOCK_SIZE) + 1;
  localparam int unsigned APW  = PW + BSW + 1;
  localparam int unsigned CNTW = $clog2(BLOCK_SIZE + 1);

  iss_pkg::ctrl_t  ctrl;
  iss_pkg::flags_t flags;

  logic [iss_pkg::AlenW-1:0] array_length_q;
  logic [iss_pkg::IlenW-1:0] index_length_q;
  logic [iss_pkg::AlenW-1:0] alen;
  logic [iss_pkg::IlenW-1:0] ilen;
  logic [APW-1:0]            alen_ext;

  logic              in_acc, search_acc, key_we, idx_we;
  logic signed [KW-1:0] key_q, lo_q, idx_rdata, key_rdata;
  logic [PW-1:0]     ip_q, pi_q;
  logic [APW-1:0]    ap_q, end_q, blk_start, blk_stop;
  logic [CNTW-1:0]   cnt_q;
  logic [AAW+iss_pkg::PosW-1:0] kw_ext;
  logic [IAW+iss_pkg::PosW-1:0] iw_ext;
  logic [AAW+APW-1:0] kr_ext;
  logic [IAW+PW-1:0]  ir_ext;
  logic [iss_pkg::CompW+CNTW-1:0] cnt_ext;

  logic                      out_valid_q, out_load;
  iss_pkg::status_e          out_status_q;
  logic [iss_pkg::PosW-1:0]  out_pos_q;
  logic [iss_pkg::CompW-1:0] out_comp_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      array_length_q <= '0;
      index_length_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        iss_pkg::REG_ARRAY_LENGTH: array_length_q <= cfg_data_i;
        iss_pkg::REG_INDEX_LENGTH: index_length_q <= cfg_data_i[iss_pkg::IlenW-1:0];
        default: ;
      endcase
    end
  end

  // lengths clipped to the store depths
  assign alen = (32'(array_length_q) > ARRAY_DEPTH) ? iss_pkg::AlenW'(ARRAY_DEPTH)
                                                     : array_length_q;
  assign ilen = (32'(index_length_q) > INDEX_DEPTH) ? iss_pkg::IlenW'(INDEX_DEPTH)
                                                     : index_length_q;
  assign alen_ext = APW'(alen);

  assign in_ready_o = ctrl.in_rdy;
  assign in_acc     = in_valid_i && in_ready_o;
  assign search_acc = in_acc && (operation_i == iss_pkg::OP_SEARCH);
  assign key_we     = in_acc && (operation_i == iss_pkg::OP_WRITE_KEY)
                      && (32'(position_i) < ARRAY_DEPTH);
  assign idx_we     = in_acc && (operation_i == iss_pkg::OP_WRITE_INDEX)
                      && (32'(position_i) < INDEX_DEPTH);

  assign kw_ext = {{AAW{1'b0}}, position_i};
  assign iw_ext = {{IAW{1'b0}}, position_i};
  assign kr_ext = {{AAW{1'b0}}, ap_q};
  assign ir_ext = {{IAW{1'b0}}, ip_q};

  iss_ram #(
    .WIDTH(KW),
    .DEPTH(ARRAY_DEPTH)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(kw_ext[AAW-1:0]),
    .wdata_i(value_i),
    .raddr_i(kr_ext[AAW-1:0]),
    .rdata_o(key_rdata)
  );

  iss_ram #(
    .WIDTH(KW),
    .DEPTH(INDEX_DEPTH)
  ) u_index_ram (
    .clk_i  (clk_i),
    .we_i   (idx_we),
    .waddr_i(iw_ext[IAW-1:0]),
    .wdata_i(value_i),
    .raddr_i(ir_ext[IAW-1:0]),
    .rdata_o(idx_rdata)
  );

  // block bounds from the matching pair
  assign blk_start = APW'(pi_q) * APW'(BLOCK_SIZE);
  assign blk_stop  = blk_start + APW'(BLOCK_SIZE);

  assign flags.search_acc = search_acc;
  assign flags.short_idx  = ilen < iss_pkg::IlenW'(2);
  // idx_rdata holds index[pi + 1] during the pair loop
  assign flags.pair_match = (key_q >= lo_q) && (key_q < idx_rdata);
  assign flags.pair_more  = ({1'b0, pi_q} + (PW + 1)'(2)) < {1'b0, ilen};
  assign flags.blk_end    = ap_q >= end_q;
  assign flags.key_hit    = key_rdata == key_q;
  assign flags.out_busy   = out_valid_q && !out_ready_i;

  iss_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .ctrl_o (ctrl)
  );

  // search datapath
  always_ff @(posedge clk_i) begin
    if (search_acc) begin
      key_q <= value_i;
      ip_q  <= '0;
      pi_q  <= '0;
    end
    if (ctrl.idx_rd) begin
      ip_q <= ip_q + PW'(1);
    end
    if (ctrl.lo_ld) begin
      lo_q <= idx_rdata;
    end
    if (ctrl.pair_step && !flags.pair_match) begin
      lo_q <= idx_rdata;
      pi_q <= pi_q + PW'(1);
    end
    if (ctrl.blk_init) begin
      ap_q  <= blk_start;
      end_q <= (blk_stop > alen_ext) ? alen_ext : blk_stop;
      cnt_q <= '0;
    end
    if (ctrl.key_cmp) begin
      cnt_q <= cnt_q + CNTW'(1);
      if (!flags.key_hit) begin
        ap_q <= ap_q + APW'(1);
      end
    end
  end

  // result register
  assign out_load = ctrl.emit && !flags.out_busy;
  assign cnt_ext  = {{iss_pkg::CompW{1'b0}}, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= ctrl.status;
      out_pos_q    <= (ctrl.status == iss_pkg::ST_FOUND) ? ap_q[iss_pkg::PosW-1:0] : '0;
      out_comp_q   <= (ctrl.status == iss_pkg::ST_NO_BLOCK) ? '0
                                                            : cnt_ext[iss_pkg::CompW-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_pos_q;
  assign comparisons_o    = out_comp_q;

  // block scan stays inside the clipped block
  `ASSERT_IMPL(a_scan_in_range, clk_i, rst_ni, ctrl.key_cmp, (ap_q < end_q) && (end_q <= alen_ext))
  // a found result always follows at least one comparison
  `ASSERT_IMPL(a_found_counted, clk_i, rst_ni, ctrl.emit && (ctrl.status == iss_pkg::ST_FOUND), cnt_q != '0)
  // a no-block result carries zero position and count
  `ASSERT_IMPL(a_noblk_zero, clk_i, rst_ni, out_valid_q && (out_status_q == iss_pkg::ST_NO_BLOCK), (out_pos_q == '0) && (out_comp_q == '0))
  // a search request closes the input until it is done
  `ASSERT_NEXT(a_search_busy, clk_i, rst_ni, search_acc, !in_ready_o)

endmodule
